// File: hdl/bmid_pkg.sv
package bmid_pkg;

    // map geometry
    localparam int SLOTS  = 1024;
    localparam int WORDS  = SLOTS / 32;
    localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int K_W    = WIDX_W + 5;

    localparam int ID_W = 16;
    localparam int ST_W = 2;

    // request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_ALLOC = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

    // request token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              op;
        logic              done;
        logic [ST_W-1:0]   status;
        logic [WIDX_W-1:0] widx;
        logic [4:0]        bidx;
    } t_token;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

endpackage

// File: hdl/bmid_cell.sv
module bmid_cell
    import bmid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [WIDX_W-1:0] i_cell_idx,
    input  t_token            i_tok,
    output t_token            o_tok
);

    logic [31:0] r_word;
    logic [31:0] n_word;
    t_token      r_tok;
    t_token      n_tok;
    logic [31:0] low_zero;
    logic [4:0]  low_idx;

    // one-hot of the lowest clear bit
    assign low_zero = ~r_word & (r_word + 32'd1);

    always_comb begin
        low_idx = '0;
        for (int b = 0; b < 32; b++) begin
            if (low_zero[b]) begin
                low_idx = low_idx | 5'(b);
            end
        end
    end

    always_comb begin
        n_tok  = i_tok;
        n_word = r_word;
        if (i_tok.valid && !i_tok.done) begin
            if (i_tok.op == OP_ALLOC) begin
                if (r_word != '1) begin
                    n_word       = r_word | low_zero;
                    n_tok.done   = 1'b1;
                    n_tok.status = ST_OK;
                    n_tok.widx   = i_cell_idx;
                    n_tok.bidx   = low_idx;
                end
            end else if (i_tok.widx == i_cell_idx) begin
                n_tok.done = 1'b1;
                if (r_word[i_tok.bidx]) begin
                    n_word[i_tok.bidx] = 1'b0;
                    n_tok.status       = ST_OK;
                end else begin
                    n_tok.status = ST_NOT_ALLOC;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word      <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_word <= n_word;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: hdl/bitmap_id_allocator_core.sv
// bitmap identifier allocator: keeps one used bit for each of SLOTS identifiers starting at
// id_base, spread over a row of SLOTS/32 cells that each own one 32-bit word of the map.
// a request (tuser 0 allocate, tuser 1 free the id in tdata) enters the first cell and moves
// one cell per clock; an allocate claims the lowest clear bit in the first cell whose word is
// not full, a free clears its bit in the cell that owns it. the result (id in tdata, status in
// tuser: 0 ok, 1 full, 2 not allocated, 3 out of range) is registered after the last cell. one
// request is in the row at a time, and a new one is taken while the previous result still waits
// on the output. reset clears the whole map at once. id_base is to be written on the cfg
// channel only while the block is idle; the block itself does not enforce this. the map is
// kept on change.
module bitmap_id_allocator_core
    import bmid_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    // configuration: id_base
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [ID_W-1:0] i_cfg_data,
    // request stream
    input  logic            i_s_axis_tvalid,
    output logic            o_s_axis_tready,
    input  logic [15:0]     i_s_axis_tdata,   // [15:0] id
    input  logic [0:0]      i_s_axis_tuser,   // [0] op
    // result stream
    output logic            o_m_axis_tvalid,
    input  logic            i_m_axis_tready,
    output logic [15:0]     o_m_axis_tdata,   // [15:0] id_out
    output logic [1:0]      o_m_axis_tuser    // [1:0] status
);

    t_state          r_state;
    t_state          n_state;
    logic [ID_W-1:0] r_id_base;

    logic            r_out_valid;
    logic [ID_W-1:0] r_out_id;
    logic [ST_W-1:0] r_out_st;
    logic [ID_W-1:0] r_hold_id;
    logic [ST_W-1:0] r_hold_st;

    logic            in_xfer;
    logic            load_out;
    logic            load_hold;
    logic            from_hold;
    logic            out_free;

    logic [ID_W:0]   diff;
    logic            in_range;
    logic [K_W-1:0]  k_in;
    logic [K_W-1:0]  k_end;
    logic [ID_W-1:0] fin_id;
    logic [ST_W-1:0] fin_st;

    t_token          tok [WORDS+1];

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_base <= '0;
        end else if (i_cfg_valid) begin
            r_id_base <= i_cfg_data;
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    // range check without wrap, offset into the map
    assign diff     = {1'b0, i_s_axis_tdata} - {1'b0, r_id_base};
    assign in_range = !diff[ID_W] && (diff[ID_W-1:0] < ID_W'(SLOTS));
    assign k_in     = diff[K_W-1:0];

    always_comb begin
        tok[0].valid  = in_xfer;
        tok[0].op     = i_s_axis_tuser[0];
        tok[0].done   = (i_s_axis_tuser[0] == OP_FREE) && !in_range;
        tok[0].status = ((i_s_axis_tuser[0] == OP_FREE) && !in_range) ? ST_RANGE : ST_OK;
        tok[0].widx   = k_in[K_W-1:5];
        tok[0].bidx   = k_in[4:0];
    end

    // row of map cells, one word each
    for (genvar g = 0; g < WORDS; g++) begin : g_cell
        bmid_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (WIDX_W'(g)),
            .i_tok      (tok[g]),
            .o_tok      (tok[g+1])
        );
    end

    // an allocate that no cell served means the map is full
    assign k_end = {tok[WORDS].widx, tok[WORDS].bidx};

    always_comb begin
        fin_st = tok[WORDS].done ? tok[WORDS].status : ST_FULL;
        fin_id = '0;
        if (tok[WORDS].op == OP_ALLOC && tok[WORDS].done) begin
            fin_id = r_id_base + ID_W'(k_end);
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state   = r_state;
        load_out  = 1'b0;
        load_hold = 1'b0;
        from_hold = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (tok[WORDS].valid) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        load_hold = 1'b1;
                        n_state   = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                // previous result still on the output
                if (out_free) begin
                    load_out  = 1'b1;
                    from_hold = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_id <= from_hold ? r_hold_id : fin_id;
            r_out_st <= from_hold ? r_hold_st : fin_st;
        end
        if (load_hold) begin
            r_hold_id <= fin_id;
            r_hold_st <= fin_st;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_id;
    assign o_m_axis_tuser  = r_out_st;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top
    import bmid_pkg::*;
();

    localparam int STALL_LIMIT = 2000;   // cycles with no transfer on any channel
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int RAND_ITEMS  = 400;
    localparam int SETTLE      = WORDS + 4;

    typedef struct packed {
        logic [ID_W-1:0] id_out;
        logic [ST_W-1:0] status;
    } t_id_result;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [ID_W-1:0] i_cfg_data = '0;
    logic            i_s_axis_tvalid = 1'b0;
    logic            o_s_axis_tready;
    logic [15:0]     i_s_axis_tdata = '0;   // [15:0] id
    logic [0:0]      i_s_axis_tuser = '0;   // [0] op
    logic            o_m_axis_tvalid;
    logic            i_m_axis_tready = 1'b0;
    logic [15:0]     o_m_axis_tdata;        // [15:0] id_out
    logic [1:0]      o_m_axis_tuser;        // [1:0] status

    // shadow of the allocator state
    logic [31:0]     id_used [WORDS] = '{default: '0};
    logic [ID_W-1:0] base_now = '0;

    t_id_result      pending_results [$];
    int              mismatches = 0;
    int              quiet_cycles = 0;
    int              sink_wait = 0;
    bit              src_idle = 1'b1;
    bit              sink_idle = 1'b1;
    bit              hold_go = 1'b0;
    logic            sink_hold = 1'b0;

    bitmap_id_allocator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // lowest clear bit on allocate, range and held checks on free
    function automatic t_id_result predict_id_result(logic op, logic [ID_W-1:0] id);
        t_id_result  r;
        int          k;
        int unsigned lo;
        int unsigned req;
        r.id_out = '0;
        r.status = ST_FULL;
        if (op == OP_ALLOC) begin
            for (k = 0; k < SLOTS; k++) begin
                if (!id_used[k / 32][k % 32]) begin
                    id_used[k / 32][k % 32] = 1'b1;
                    r.id_out = ID_W'(base_now + k);
                    r.status = ST_OK;
                    break;
                end
            end
        end else begin
            lo  = base_now;
            req = id;
            // range is compared without wrap
            if (req < lo || req >= lo + SLOTS) begin
                r.status = ST_RANGE;
            end else begin
                k = req - lo;
                if (id_used[k / 32][k % 32]) begin
                    id_used[k / 32][k % 32] = 1'b0;
                    r.status = ST_OK;
                end else begin
                    r.status = ST_NOT_ALLOC;
                end
            end
        end
        return r;
    endfunction

    // some currently held id, searched from a random slot
    function automatic logic [ID_W-1:0] held_id_at_random();
        int start;
        int j;
        int k;
        start = $urandom_range(0, SLOTS - 1);
        for (j = 0; j < SLOTS; j++) begin
            k = (start + j) % SLOTS;
            if (id_used[k / 32][k % 32])
                return ID_W'(base_now + k);
        end
        return ID_W'(base_now + start);
    endfunction

    // one request transfer; tvalid is left high for a back-to-back follower
    task automatic issue_request(input logic op, input logic [ID_W-1:0] id);
        int gap;
        gap = src_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= id;
        i_s_axis_tuser  <= op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_id_result(op, id));
    endtask

    task automatic issue_alloc();
        issue_request(OP_ALLOC, ID_W'($urandom_range(0, 65535)));
    endtask

    // stop sending, wait for every result, then let the cell row empty
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [ID_W-1:0] value);
        settle_block();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        base_now = value;
    endtask

    // id 0 is a normal success; freed ids are reused lowest first
    task automatic test_reset_alloc();
        repeat (4) issue_alloc();
        issue_request(OP_FREE, 16'd1);
        issue_request(OP_FREE, 16'd1);
        issue_alloc();
        issue_request(OP_FREE, 16'hFFFF);
        issue_request(OP_FREE, 16'(SLOTS));
        issue_request(OP_FREE, 16'(SLOTS - 1));
        settle_block();
    endtask

    // map kept across a base change; ranges below, above and wrapping past 65535
    task automatic test_base_change();
        write_base(16'h1000);
        issue_alloc();
        issue_request(OP_FREE, 16'h0FFF);
        issue_request(OP_FREE, 16'h1000);
        issue_request(OP_FREE, 16'(16'h1000 + SLOTS));
        issue_request(OP_FREE, 16'(16'h1000 + SLOTS - 1));
        write_base(16'hFFFF);
        issue_alloc();
        issue_alloc();
        issue_request(OP_FREE, 16'hFFFF);
        issue_request(OP_FREE, 16'h0000);
        issue_alloc();
        settle_block();
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        int n;
        src_idle = 1'b0;
        hold_go  = 1'b1;
        for (n = 0; n < 10; n++) begin
            if (n % 3 == 2)
                issue_request(OP_FREE, held_id_at_random());
            else
                issue_alloc();
        end
        settle_block();
        src_idle = 1'b1;
    endtask

    task automatic test_random_mix();
        int              n;
        int              alloc_pct;
        int              pick;
        logic [ID_W-1:0] id;
        alloc_pct = 50;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 100 == 0) begin
                case (n / 100)
                    0:       write_base(16'h0000);
                    1:       write_base(ID_W'($urandom_range(0, 65535)));
                    2:       write_base(16'(16'hFFFF - SLOTS / 2));   // wraps on allocate
                    default: write_base(ID_W'($urandom_range(0, 65535 - SLOTS)));
                endcase
            end
            if (n % 100 == 0) begin
                case ($urandom_range(0, 3))
                    0:       alloc_pct = 20;
                    1:       alloc_pct = 50;
                    2:       alloc_pct = 80;
                    default: alloc_pct = 95;
                endcase
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 99) < alloc_pct) begin
                issue_alloc();
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    id = held_id_at_random();
                else if (pick < 85)
                    id = ID_W'(base_now + $urandom_range(0, SLOTS - 1));
                else
                    id = ID_W'($urandom_range(0, 65535));
                issue_request(OP_FREE, id);
            end
        end
        settle_block();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // allocate every free slot, then a few more which must report full
    task automatic test_fill_full();
        int k;
        int free_slots;
        write_base(16'h4000);
        free_slots = 0;
        for (k = 0; k < SLOTS; k++)
            if (!id_used[k / 32][k % 32])
                free_slots++;
        repeat (free_slots + 3) issue_alloc();
        issue_request(OP_FREE, 16'(16'h4000 + SLOTS - 1));
        issue_request(OP_FREE, 16'(16'h4000 + SLOTS - 1));
        issue_alloc();
        issue_request(OP_FREE, held_id_at_random());
        issue_request(OP_FREE, held_id_at_random());
        repeat (3) issue_alloc();
        settle_block();
    endtask

    // long hold-off of the receiver, counted here
    initial begin : long_hold
        int n;
        wait (hold_go);
        @(posedge i_clk);
        sink_hold <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++)
            @(posedge i_clk);
        sink_hold <= 1'b0;
    end

    // result ready: random wait after each transfer
    always @(posedge i_clk) begin : sink_ctl
        int gap;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_wait       <= 0;
        end else if (sink_hold) begin
            i_m_axis_tready <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            gap = sink_idle ? $urandom_range(0, 10) : 0;
            sink_wait       <= gap;
            i_m_axis_tready <= (gap == 0);
        end else if (sink_wait != 0) begin
            sink_wait       <= sink_wait - 1;
            i_m_axis_tready <= (sink_wait == 1);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_id_result exp_r;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, actual id %h status %0d",
                         $time, o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                exp_r = pending_results.pop_front();
                if (o_m_axis_tdata !== exp_r.id_out) begin
                    mismatches++;
                    $display("%0t: id_out mismatch: expected %h, actual %h",
                             $time, exp_r.id_out, o_m_axis_tdata);
                end
                if (o_m_axis_tuser !== exp_r.status) begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, exp_r.status, o_m_axis_tuser);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
            || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_alloc();
        test_base_change();
        test_backpressure();
        test_random_mix();
        test_fill_full();
        settle_block();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
